// File: sv/wtoa_pkg.sv
// Shared types and codes for the weighted tile overlap accumulator.
package wtoa_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ACC   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_UNCOV  = 2'd2;

  localparam logic [2:0] CFG_VOL_W   = 3'd0;
  localparam logic [2:0] CFG_VOL_H   = 3'd1;
  localparam logic [2:0] CFG_VOL_D   = 3'd2;
  localparam logic [2:0] CFG_PAT_W   = 3'd3;
  localparam logic [2:0] CFG_PAT_H   = 3'd4;
  localparam logic [2:0] CFG_PAT_D   = 3'd5;
  localparam logic [2:0] CFG_CLS_CNT = 3'd6;

  typedef struct packed {
    logic [5:0] vol_w;
    logic [5:0] vol_h;
    logic [5:0] vol_d;
    logic [4:0] pat_w;
    logic [4:0] pat_h;
    logic [4:0] pat_d;
    logic [2:0] cls_cnt;
  } cfg_t;

  // Classified command handed from front to back.
  typedef struct packed {
    req_e req;
    logic err;
    logic cls0;
  } cmd_t;

endpackage

// File: sv/weighted_tile_overlap_accumulator.sv
// Per item, from accept: a load or a rejected item ends in idle; an accumulate looks
// up, multiplies, updates; a read looks up, then ends if uncovered or else divides.
// Clear walks all MAX_VOLUME_EDGE^3*MAX_CLASSES accumulator entries, one entry a cycle.
// One item at a time: busy stays high from accept until done_o.
// Reset is asynchronous; after reset the same clear walk runs with busy high.
// Results appear for one cycle with done_o; the receiver cannot stall.
module weighted_tile_overlap_accumulator #(
  parameter int MAX_VOLUME_EDGE = 32,
  parameter int MAX_PATCH_EDGE  = 16,
  parameter int MAX_CLASSES     = 4,
  parameter int ACC_WIDTH       = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [4:0]         origin_x_i,
  input  logic [4:0]         origin_y_i,
  input  logic [4:0]         origin_z_i,
  input  logic [3:0]         local_x_i,
  input  logic [3:0]         local_y_i,
  input  logic [3:0]         local_z_i,
  input  logic [1:0]         class_index_i,
  input  logic signed [15:0] score_value_i,
  input  logic [15:0]        weight_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] read_value_o
);

  localparam int VOX_AW = $clog2(MAX_VOLUME_EDGE ** 3);
  localparam int ACC_AW = $clog2((MAX_VOLUME_EDGE ** 3) * MAX_CLASSES);
  localparam int W_AW   = (MAX_PATCH_EDGE > 1) ? $clog2(MAX_PATCH_EDGE ** 3) : 1;
  localparam int CMD_W  = $bits(wtoa_pkg::cmd_t);
  localparam int QW     = CMD_W + W_AW + VOX_AW + ACC_AW + 32;

  wtoa_pkg::cfg_t    cfg_q;
  wtoa_pkg::cmd_t    f_cmd, b_cmd;
  logic [W_AW-1:0]   f_widx, b_widx;
  logic [VOX_AW-1:0] f_vox, b_vox;
  logic [ACC_AW-1:0] f_aidx, b_aidx;
  logic [15:0]       b_score, b_weight;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_valid, q_pop, boot, pending_q, accept;
  logic [15:0]       value;

  assign cfg_ready_o  = 1'b1;
  assign accept       = start && !busy;
  assign busy         = pending_q || boot;
  assign read_value_o = $signed(value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vol_w   <= 6'd32;
      cfg_q.vol_h   <= 6'd32;
      cfg_q.vol_d   <= 6'd32;
      cfg_q.pat_w   <= 5'd16;
      cfg_q.pat_h   <= 5'd16;
      cfg_q.pat_d   <= 5'd1;
      cfg_q.cls_cnt <= 3'd4;
      pending_q     <= 1'b0;
    end else begin
      if (accept) pending_q <= 1'b1;
      else if (done_o) pending_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          wtoa_pkg::CFG_VOL_W:   cfg_q.vol_w   <= cfg_data_i;
          wtoa_pkg::CFG_VOL_H:   cfg_q.vol_h   <= cfg_data_i;
          wtoa_pkg::CFG_VOL_D:   cfg_q.vol_d   <= cfg_data_i;
          wtoa_pkg::CFG_PAT_W:   cfg_q.pat_w   <= cfg_data_i[4:0];
          wtoa_pkg::CFG_PAT_H:   cfg_q.pat_h   <= cfg_data_i[4:0];
          wtoa_pkg::CFG_PAT_D:   cfg_q.pat_d   <= cfg_data_i[4:0];
          wtoa_pkg::CFG_CLS_CNT: cfg_q.cls_cnt <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  wtoa_front #(
    .MAX_VOLUME_EDGE(MAX_VOLUME_EDGE),
    .MAX_PATCH_EDGE (MAX_PATCH_EDGE),
    .MAX_CLASSES    (MAX_CLASSES)
  ) u_front (
    .cfg_i        (cfg_q),
    .req_type_i   (req_type_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .origin_z_i   (origin_z_i),
    .local_x_i    (local_x_i),
    .local_y_i    (local_y_i),
    .local_z_i    (local_z_i),
    .class_index_i(class_index_i),
    .cmd_o        (f_cmd),
    .widx_o       (f_widx),
    .vox_o        (f_vox),
    .aidx_o       (f_aidx)
  );

  assign q_wdata = {f_cmd, f_widx, f_vox, f_aidx, score_value_i, weight_value_i};

  wtoa_queue #(.WIDTH(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign {b_cmd, b_widx, b_vox, b_aidx, b_score, b_weight} = q_rdata;

  wtoa_back #(
    .MAX_VOLUME_EDGE(MAX_VOLUME_EDGE),
    .MAX_PATCH_EDGE (MAX_PATCH_EDGE),
    .MAX_CLASSES    (MAX_CLASSES),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .cmd_i    (b_cmd),
    .widx_i   (b_widx),
    .vox_i    (b_vox),
    .aidx_i   (b_aidx),
    .score_i  (b_score),
    .weight_i (b_weight),
    .boot_o   (boot),
    .done_o   (done_o),
    .status_o (status_o),
    .value_o  (value)
  );

endmodule

// File: sv/wtoa_front.sv
// Front end: range checks and address generation for one item.
module wtoa_front #(
  parameter int MAX_VOLUME_EDGE = 32,
  parameter int MAX_PATCH_EDGE  = 16,
  parameter int MAX_CLASSES     = 4,
  localparam int VOX_AW = $clog2(MAX_VOLUME_EDGE ** 3),
  localparam int ACC_AW = $clog2((MAX_VOLUME_EDGE ** 3) * MAX_CLASSES),
  localparam int W_AW   = (MAX_PATCH_EDGE > 1) ? $clog2(MAX_PATCH_EDGE ** 3) : 1
) (
  input  wtoa_pkg::cfg_t     cfg_i,
  input  logic [1:0]         req_type_i,
  input  logic [4:0]         origin_x_i,
  input  logic [4:0]         origin_y_i,
  input  logic [4:0]         origin_z_i,
  input  logic [3:0]         local_x_i,
  input  logic [3:0]         local_y_i,
  input  logic [3:0]         local_z_i,
  input  logic [1:0]         class_index_i,
  output wtoa_pkg::cmd_t     cmd_o,
  output logic [W_AW-1:0]    widx_o,
  output logic [VOX_AW-1:0]  vox_o,
  output logic [ACC_AW-1:0]  aidx_o
);

  function automatic logic [8:0] eff(logic [5:0] v, int maxv);
    logic [8:0] r;
    if (v == 6'd0) r = 9'd1;
    else if (int'(v) > maxv) r = 9'(maxv);
    else r = {3'b0, v};
    return r;
  endfunction

  logic [8:0] vw, vh, vd, pw, ph, pd, cc;
  logic [5:0] gx, gy, gz, cx, cy, cz;
  logic       loc_bad, glb_bad, org_bad, cls_bad;
  wtoa_pkg::req_e req;

  always_comb begin
    req = wtoa_pkg::req_e'(req_type_i);
    vw = eff(cfg_i.vol_w, MAX_VOLUME_EDGE);
    vh = eff(cfg_i.vol_h, MAX_VOLUME_EDGE);
    vd = eff(cfg_i.vol_d, MAX_VOLUME_EDGE);
    pw = eff({1'b0, cfg_i.pat_w}, MAX_PATCH_EDGE);
    ph = eff({1'b0, cfg_i.pat_h}, MAX_PATCH_EDGE);
    pd = eff({1'b0, cfg_i.pat_d}, MAX_PATCH_EDGE);
    cc = eff({3'b0, cfg_i.cls_cnt}, MAX_CLASSES);
    gx = {1'b0, origin_x_i} + {2'b0, local_x_i};
    gy = {1'b0, origin_y_i} + {2'b0, local_y_i};
    gz = {1'b0, origin_z_i} + {2'b0, local_z_i};
    loc_bad = ({5'b0, local_x_i} >= pw) || ({5'b0, local_y_i} >= ph) ||
              ({5'b0, local_z_i} >= pd);
    glb_bad = ({3'b0, gx} >= vw) || ({3'b0, gy} >= vh) || ({3'b0, gz} >= vd);
    org_bad = ({4'b0, origin_x_i} >= vw) || ({4'b0, origin_y_i} >= vh) ||
              ({4'b0, origin_z_i} >= vd);
    cls_bad = {7'b0, class_index_i} >= cc;

    unique case (req)
      wtoa_pkg::REQ_LOAD:  cmd_o.err = loc_bad;
      wtoa_pkg::REQ_ACC:   cmd_o.err = loc_bad || glb_bad || cls_bad;
      wtoa_pkg::REQ_READ:  cmd_o.err = org_bad || cls_bad;
      default:             cmd_o.err = 1'b0;
    endcase
    cmd_o.req  = req;
    cmd_o.cls0 = (class_index_i == 2'd0);

    // reads address the origin voxel, accumulates the shifted one
    if (req == wtoa_pkg::REQ_READ) begin
      cx = {1'b0, origin_x_i};
      cy = {1'b0, origin_y_i};
      cz = {1'b0, origin_z_i};
    end else begin
      cx = gx;
      cy = gy;
      cz = gz;
    end
    widx_o = W_AW'((int'(local_z_i) * MAX_PATCH_EDGE + int'(local_y_i)) * MAX_PATCH_EDGE
                   + int'(local_x_i));
    vox_o  = VOX_AW'((int'(cz) * MAX_VOLUME_EDGE + int'(cy)) * MAX_VOLUME_EDGE + int'(cx));
    aidx_o = ACC_AW'(int'(vox_o) * MAX_CLASSES + int'(class_index_i));
  end

endmodule

// File: sv/wtoa_queue.sv
// Two-entry queue between the front end and the back end.
module wtoa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i && valid_o);
    end
  end

endmodule

// File: sv/wtoa_back.sv
// Back end: weight table, accumulator and coverage stores, divider, clear walk.
module wtoa_back #(
  parameter int MAX_VOLUME_EDGE = 32,
  parameter int MAX_PATCH_EDGE  = 16,
  parameter int MAX_CLASSES     = 4,
  parameter int ACC_WIDTH       = 40,
  localparam int VOX_DEPTH = MAX_VOLUME_EDGE ** 3,
  localparam int ACC_DEPTH = VOX_DEPTH * MAX_CLASSES,
  localparam int W_DEPTH   = MAX_PATCH_EDGE ** 3,
  localparam int VOX_AW = $clog2(VOX_DEPTH),
  localparam int ACC_AW = $clog2(ACC_DEPTH),
  localparam int W_AW   = (MAX_PATCH_EDGE > 1) ? $clog2(W_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  wtoa_pkg::cmd_t     cmd_i,
  input  logic [W_AW-1:0]    widx_i,
  input  logic [VOX_AW-1:0]  vox_i,
  input  logic [ACC_AW-1:0]  aidx_i,
  input  logic [15:0]        score_i,
  input  logic [15:0]        weight_i,
  output logic               boot_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [15:0]        value_o
);

  localparam int CW = $clog2(ACC_WIDTH + 1);
  localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_MUL, S_UPD, S_CHK, S_DIV
  } state_e;

  state_e state_q;

  logic [15:0]          wt_mem  [W_DEPTH];
  logic [ACC_WIDTH-1:0] acc_mem [ACC_DEPTH];
  logic [31:0]          cov_mem [VOX_DEPTH];
  logic [15:0]          wt_rd_q;
  logic [ACC_WIDTH-1:0] acc_rd_q;
  logic [31:0]          cov_rd_q;

  wtoa_pkg::cmd_t         cmd_q;
  logic [W_AW-1:0]        widx_q;
  logic [VOX_AW-1:0]      vox_q;
  logic [ACC_AW-1:0]      aidx_q;
  logic signed [15:0]     score_q;
  logic [ACC_AW-1:0]      ptr_q;
  logic                   clr_emit_q;
  logic signed [32:0]     prod_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic [15:0]            w_q;
  logic [31:0]            cov_q;
  logic [ACC_WIDTH-1:0]   dvd_q;
  logic [31:0]            rem_q;
  logic [CW-1:0]          cnt_q;
  logic                   neg_q;

  logic                   wt_we;
  logic                   acc_we, cov_we;
  logic [ACC_AW-1:0]      acc_wa;
  logic [VOX_AW-1:0]      cov_wa;
  logic [ACC_WIDTH-1:0]   acc_wd;
  logic [31:0]            cov_wd;
  logic signed [ACC_WIDTH:0] sum;
  logic [32:0]            cov_sum;
  logic [32:0]            rem_sh;
  logic                   rem_ge;
  logic [ACC_WIDTH-1:0]   mag;
  logic [ACC_WIDTH-1:0]   quo;

  assign boot_o  = (state_q == S_CLEAR) && !clr_emit_q;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    sum     = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(prod_q);
    cov_sum = {1'b0, cov_q} + {17'b0, w_q};
    rem_sh  = {rem_q, dvd_q[ACC_WIDTH-1]};
    rem_ge  = rem_sh >= {1'b0, cov_q};
    mag     = acc_rd_q[ACC_WIDTH-1] ? (~acc_rd_q + 1'b1) : acc_rd_q;
    quo     = {dvd_q[ACC_WIDTH-2:0], rem_ge};

    wt_we  = q_pop_o && (cmd_i.req == wtoa_pkg::REQ_LOAD) && !cmd_i.err;
    acc_we = 1'b0;
    cov_we = 1'b0;
    acc_wa = aidx_q;
    cov_wa = vox_q;
    acc_wd = '0;
    cov_wd = '0;
    if (state_q == S_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = ptr_q;
      cov_we = int'(ptr_q) < VOX_DEPTH;
      cov_wa = VOX_AW'(ptr_q);
    end else if (state_q == S_UPD) begin
      acc_we = 1'b1;
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) acc_wd = sum[ACC_WIDTH] ? AMIN : AMAX;
      else acc_wd = sum[ACC_WIDTH-1:0];
      cov_we = cmd_q.cls0;
      cov_wd = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[widx_i] <= weight_i;
    wt_rd_q <= wt_mem[widx_q];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd_q <= acc_mem[aidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cov_we) cov_mem[cov_wa] <= cov_wd;
    cov_rd_q <= cov_mem[vox_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q   <= cmd_i;
      widx_q  <= widx_i;
      vox_q   <= vox_i;
      aidx_q  <= aidx_i;
      score_q <= score_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= score_q * $signed({1'b0, wt_rd_q});
      acc_q  <= acc_rd_q;
      w_q    <= wt_rd_q;
      cov_q  <= cov_rd_q;
    end
    if (state_q == S_CHK) begin
      cov_q <= cov_rd_q;
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= acc_rd_q[ACC_WIDTH-1];
      cnt_q <= CW'(ACC_WIDTH);
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_ge ? 32'(rem_sh - {1'b0, cov_q}) : rem_sh[31:0];
      dvd_q <= quo;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      ptr_q      <= '0;
      clr_emit_q <= 1'b0;
      done_o     <= 1'b0;
      status_o   <= wtoa_pkg::ST_OK;
      value_o    <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (int'(ptr_q) == ACC_DEPTH - 1) begin
            ptr_q      <= '0;
            state_q    <= S_IDLE;
            clr_emit_q <= 1'b0;
            if (clr_emit_q) begin
              done_o   <= 1'b1;
              status_o <= wtoa_pkg::ST_OK;
              value_o  <= '0;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            if (cmd_i.err) begin
              done_o   <= 1'b1;
              status_o <= wtoa_pkg::ST_RANGE;
              value_o  <= '0;
            end else begin
              unique case (cmd_i.req)
                wtoa_pkg::REQ_LOAD: begin
                  done_o   <= 1'b1;
                  status_o <= wtoa_pkg::ST_OK;
                  value_o  <= '0;
                end
                wtoa_pkg::REQ_CLEAR: begin
                  state_q    <= S_CLEAR;
                  clr_emit_q <= 1'b1;
                end
                default: state_q <= S_LOOK;
              endcase
            end
          end
        end
        S_LOOK: state_q <= (cmd_q.req == wtoa_pkg::REQ_ACC) ? S_MUL : S_CHK;
        S_MUL:  state_q <= S_UPD;
        S_UPD: begin
          done_o   <= 1'b1;
          status_o <= wtoa_pkg::ST_OK;
          value_o  <= '0;
          state_q  <= S_IDLE;
        end
        S_CHK: begin
          if (cov_rd_q == 32'd0) begin
            done_o   <= 1'b1;
            status_o <= wtoa_pkg::ST_UNCOV;
            value_o  <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == CW'(1)) begin
            done_o   <= 1'b1;
            status_o <= wtoa_pkg::ST_OK;
            if (neg_q) value_o <= (quo > ACC_WIDTH'(32768)) ? 16'h8000 : 16'(~quo + 1'b1);
            else       value_o <= (quo > ACC_WIDTH'(32767)) ? 16'h7FFF : quo[15:0];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
